[rtl/itaf_pkg.sv]
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared types, constants and lookup functions for the integer-to-ASCII
// formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

    localparam int MAX_WIDTH_DEF = 31;
    localparam int TEXT_CAP      = 16;
    localparam int TXT_W         = $clog2(TEXT_CAP);
    localparam int QUEUE_DEPTH   = 2;
    localparam int DIVS_W        = 21;

    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [7:0] SOS_UNSIGNED = 8'd0;
    localparam logic [7:0] SOS_SIGNED   = 8'd1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_K     = 8'h4B;

    typedef enum logic [2:0] {
        PATH_ZERO,
        PATH_OCT,
        PATH_DEC,
        PATH_HEX,
        PATH_COMPACT,
        PATH_GROUP
    } path_t;

    typedef struct packed {
        logic [31:0] mag;
        path_t       path;
        logic        neg;
        logic [7:0]  sep;
        logic [4:0]  field_width;
        logic [7:0]  pad_char;
        logic        left_justify;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_DIVW,
        ST_KMUL,
        ST_KRES,
        ST_ROUND,
        ST_MUL,
        ST_DIG,
        ST_SHIFT,
        ST_SIGN,
        ST_EMIT
    } back_state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = CH_UPPER + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

    // compact scale select: 0..6 scale rows, 7 no scaling
    function automatic logic [2:0] scale_sel(input logic [31:0] n);
        logic [2:0] s;
        if (n[31:30] != 2'd0)
            s = 3'd0;
        else if (n[31:20] >= 12'd100)
            s = 3'd1;
        else if (n[31:20] >= 12'd10)
            s = 3'd2;
        else if (n[31:20] != 12'd0)
            s = 3'd3;
        else if (n[31:10] >= 22'd100)
            s = 3'd4;
        else if (n[31:10] >= 22'd10)
            s = 3'd5;
        else if (n[31:10] != 22'd0)
            s = 3'd6;
        else
            s = 3'd7;
        return s;
    endfunction

    function automatic logic [DIVS_W-1:0] scale_divisor(input logic [2:0] s);
        logic [DIVS_W-1:0] d;
        case (s)
            3'd0:    d = DIVS_W'(1073741);
            3'd1:    d = DIVS_W'(104857);
            3'd2:    d = DIVS_W'(10485);
            default: d = DIVS_W'(1048);
        endcase
        return d;
    endfunction

    // floor(2^32 / d) for each G/M divisor; estimate is low by at most one
    function automatic logic [31:0] scale_recip(input logic [DIVS_W-1:0] d);
        logic [31:0] m;
        case (d)
            DIVS_W'(1073741): m = 32'd4000;
            DIVS_W'(104857):  m = 32'd40960;
            DIVS_W'(10485):   m = 32'd409629;
            default:          m = 32'd4098251;
        endcase
        return m;
    endfunction

    function automatic logic [9:0] scale_mul(input logic [2:0] s);
        logic [9:0] m;
        case (s)
            3'd4:    m = 10'd10;
            3'd5:    m = 10'd100;
            default: m = 10'd1000;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] scale_letter(input logic [2:0] s);
        logic [7:0] c;
        case (s)
            3'd0:    c = CH_G;
            3'd1, 3'd2, 3'd3: c = CH_M;
            default: c = CH_K;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] scale_decimals(input logic [2:0] s);
        logic [1:0] f;
        case (s)
            3'd0, 3'd3, 3'd6: f = 2'd2;
            3'd2, 3'd5:       f = 2'd1;
            default:          f = 2'd0;
        endcase
        return f;
    endfunction

endpackage

[rtl/itaf_if.sv]
// ----------------------------------------------------------------------------
// itaf interfaces
// Valid/ready channels: input item, output character, configuration write.
// ----------------------------------------------------------------------------
interface itaf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [1:0]  radix;
    logic [7:0]  sign_or_separator;
    logic [4:0]  field_width;
    logic [7:0]  pad_char;
    logic        left_justify;

    modport source (output valid, value, radix, sign_or_separator, field_width,
                    pad_char, left_justify, input ready);
    modport sink (input valid, value, radix, sign_or_separator, field_width,
                  pad_char, left_justify, output ready);
endinterface

interface itaf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, character, last, input ready);
    modport sink (input valid, character, last, output ready);
endinterface

interface itaf_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/integer_to_ascii_formatter_top.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats a 32-bit value as octal, decimal, hex, grouped decimal or compact
// K/M/G text and streams it out one character at a time, padded to width.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                      | accept
//  --------+-----+----------------------------------------------+------------
//  num     | in  | value, radix, sign_or_separator, field_width,| valid&ready
//          |     | pad_char, left_justify                       |
//  txt     | out | character, last                              | valid&ready
//  cfg     | in  | data = long_number_mode                      | valid&ready
//
//  Steps: pop, classify and sign, then a reciprocal multiply and a digit
//  step per decimal digit, or a shift per octal/hex digit; compact form adds
//  rounding and G/M scaling in the reciprocal divider or K scaling; then one
//  character per cycle while txt is ready.
//  Reset: rst_n async low; clears control, long_number_mode to 0.
//  Stalls: a two-entry item queue separates intake from the digit engine;
//  the output register holds a character while txt.ready is low.
//
module integer_to_ascii_formatter_top
    import itaf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    itaf_in_if.sink    num,
    itaf_cfg_if.sink   cfg,
    itaf_out_if.source txt
);

    // classified items between intake and the digit engine
    logic job_valid;
    job_t job;
    logic job_pop;

    itaf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .num       (num),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    // digit generation, text buffer and padded character stream
    itaf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .txt       (txt)
    );

endmodule

[rtl/itaf_front.sv]
// ----------------------------------------------------------------------------
// itaf_front
// Accepts items, classifies them into a formatting path and queues them.
// ----------------------------------------------------------------------------
module itaf_front
    import itaf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    itaf_in_if.sink    num,
    itaf_cfg_if.sink   cfg,
    output logic       job_valid,
    output job_t       job,
    input  logic       job_pop
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    logic            lnm_reg;
    job_t            q_reg [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_reg, wr_next;
    logic [QA_W-1:0] rd_reg, rd_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;
    job_t            cls;
    logic            push;
    logic            neg;

    assign cfg.ready = 1'b1;
    assign num.ready = (cnt_reg != QC_W'(QUEUE_DEPTH));
    assign push      = num.valid && num.ready;
    assign job_valid = (cnt_reg != '0);
    assign job       = q_reg[rd_reg];

    always_comb
    begin
        neg                = (num.sign_or_separator != SOS_UNSIGNED) && num.value[31];
        cls.mag            = neg ? (32'd0 - num.value) : num.value;
        cls.neg            = neg;
        cls.sep            = num.sign_or_separator;
        cls.field_width    = num.field_width;
        cls.pad_char       = num.pad_char;
        cls.left_justify   = num.left_justify;
        if (num.value == 32'd0)
            cls.path = PATH_ZERO;
        else if (num.sign_or_separator != SOS_UNSIGNED &&
                 num.sign_or_separator != SOS_SIGNED)
            cls.path = lnm_reg ? PATH_GROUP : PATH_COMPACT;
        else if (num.radix == RADIX_OCT)
            cls.path = PATH_OCT;
        else if (num.radix == RADIX_HEX)
            cls.path = PATH_HEX;
        else
            cls.path = PATH_DEC;
    end

    always_comb
    begin
        wr_next  = push ? QA_W'((32'(wr_reg) + 1) % QUEUE_DEPTH) : wr_reg;
        rd_next  = job_pop ? QA_W'((32'(rd_reg) + 1) % QUEUE_DEPTH) : rd_reg;
        cnt_next = cnt_reg + QC_W'(push) - QC_W'(job_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lnm_reg <= 1'b0;
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
                lnm_reg <= cfg.data;
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= cls;
    end

endmodule

[rtl/itaf_div.sv]
// ----------------------------------------------------------------------------
// itaf_div
// Divider for the G/M scale constants: reciprocal multiply, back-multiply and
// one correction step, each registered; done follows start through a shift register.
// ----------------------------------------------------------------------------
module itaf_div
    import itaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [31:0]       quotient
);

    logic [3:0]        stg_reg;
    logic              done_reg;
    logic [31:0]       dvd_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [31:0]       rcp_reg;
    logic [63:0]       pa_reg;
    logic [31:0]       q0_reg;
    logic [63:0]       pb_reg;
    logic [31:0]       quo_reg;
    logic [31:0]       rem;

    assign done     = done_reg;
    assign quotient = quo_reg;
    // remainder of the estimate, below twice the divisor
    assign rem      = dvd_reg - pb_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            stg_reg  <= {stg_reg[2:0], start};
            done_reg <= stg_reg[3];
        end
    end

    // operands hold from start until the next start
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rcp_reg <= scale_recip(divisor);
        end
        pa_reg  <= 64'(dvd_reg) * 64'(rcp_reg);
        q0_reg  <= pa_reg[63:32];
        pb_reg  <= 64'(q0_reg) * 64'(dvs_reg);
        quo_reg <= (rem >= 32'(dvs_reg)) ? q0_reg + 32'd1 : q0_reg;
    end

endmodule

[rtl/itaf_back.sv]
// ----------------------------------------------------------------------------
// itaf_back
// Digit engine and character emitter: builds the text least significant
// first in a small buffer, then streams pad and text characters out.
// ----------------------------------------------------------------------------
module itaf_back
    import itaf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_pop,
    itaf_out_if.source txt
);

    localparam int PW = $clog2(MAX_WIDTH + 1);

    back_state_t      state_reg, state_next;
    job_t             job_reg;
    logic [31:0]      n_reg, n_next;
    logic [63:0]      prod_reg;
    logic [31:0]      mul_b;
    logic [TXT_W-1:0] len_reg, len_next;
    logic [1:0]       frac_reg, frac_next;
    logic [1:0]       grp_reg, grp_next;
    logic             rnd_reg, rnd_next;
    logic [9:0]       kmul_reg;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [7:0]       text_reg [TEXT_CAP];
    logic             ov_reg, ov_next;
    logic [7:0]       och_reg;
    logic             olast_reg;

    logic             wr0, wr1;
    logic [7:0]       wd0, wd1;
    logic [2:0]       sel;
    logic             div_start, div_done;
    logic [31:0]      div_q;
    logic [31:0]      q, q10;
    logic [3:0]       r;
    logic             put, dot;
    logic [TXT_W-1:0] len1;
    logic [PW-1:0]    wid, len_e, padn, total, tpos;
    logic             in_text, load, last;

    assign job_pop   = (state_reg == ST_IDLE) && job_valid;
    assign txt.valid = ov_reg;
    assign txt.character = och_reg;
    assign txt.last  = olast_reg;

    itaf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (scale_divisor(sel)),
        .done     (div_done),
        .quotient (div_q)
    );

    // shared multiplier: reciprocal of ten, or the K scale factor
    assign mul_b = (state_reg == ST_KMUL) ? {22'd0, kmul_reg} : RECIP_10;

    always_ff @(posedge clk)
    begin
        prod_reg <= n_reg * mul_b;
    end

    always_comb
    begin
        sel  = scale_sel(n_reg);
        q    = {3'd0, prod_reg[63:35]};
        q10  = {q[28:0], 3'd0} + {q[30:0], 1'd0};
        r    = 4'(n_reg - q10);
        put  = (r != 4'd0) || (frac_reg == 2'd0) || (len_reg > TXT_W'(1));
        len1 = len_reg + TXT_W'(put);
        dot  = (frac_reg == 2'd1) && (len1 > TXT_W'(1));
    end

    // emit geometry
    always_comb
    begin
        if ({2'd0, job_reg.field_width} > 7'(MAX_WIDTH))
            wid = PW'(MAX_WIDTH);
        else
            wid = PW'(job_reg.field_width);
        len_e = PW'(len_reg);
        padn  = (wid > len_e) ? PW'(wid - len_e) : '0;
        total = PW'(len_e + padn);
        if (job_reg.left_justify)
        begin
            in_text = (pos_reg < len_e);
            tpos    = PW'(len_e - PW'(1) - pos_reg);
        end
        else
        begin
            in_text = (pos_reg >= padn);
            tpos    = PW'(total - PW'(1) - pos_reg);
        end
        last    = (pos_reg == PW'(total - PW'(1)));
        load    = (state_reg == ST_EMIT) && (!ov_reg || txt.ready);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (job_valid)
                    state_next = ST_CLASS;
            ST_CLASS:
                case (job_reg.path)
                    PATH_ZERO:            state_next = ST_SIGN;
                    PATH_OCT, PATH_HEX:   state_next = ST_SHIFT;
                    PATH_COMPACT:
                        if (sel < 3'd4)
                            state_next = ST_DIVW;
                        else if (sel != 3'd7)
                            state_next = ST_KMUL;
                        else
                            state_next = ST_MUL;
                    default:              state_next = ST_MUL;
                endcase
            ST_DIVW:
                if (div_done)
                    state_next = ST_ROUND;
            ST_KMUL:  state_next = ST_KRES;
            ST_KRES:  state_next = ST_ROUND;
            ST_ROUND: state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIG;
            ST_DIG:
                state_next = (q == 32'd0) ? ST_SIGN : ST_MUL;
            ST_SHIFT:
                if (n_next == 32'd0)
                    state_next = ST_SIGN;
            ST_SIGN:  state_next = ST_EMIT;
            ST_EMIT:
                if (load && last)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        n_next    = n_reg;
        len_next  = len_reg;
        frac_next = frac_reg;
        grp_next  = grp_reg;
        rnd_next  = rnd_reg;
        pos_next  = pos_reg;
        wr0       = 1'b0;
        wr1       = 1'b0;
        wd0       = CH_ZERO;
        wd1       = CH_DOT;
        div_start = 1'b0;
        ov_next   = ov_reg;
        if (txt.ready)
            ov_next = 1'b0;
        if (load)
            ov_next = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                n_next   = job.mag;
                len_next = '0;
                grp_next = '0;
                rnd_next = 1'b0;
                frac_next = '0;
            end
            ST_CLASS:
            begin
                if (job_reg.path == PATH_ZERO)
                begin
                    wr0      = 1'b1;
                    wd0      = CH_ZERO;
                    len_next = TXT_W'(1);
                end
                else if (job_reg.path == PATH_COMPACT)
                begin
                    frac_next = scale_decimals(sel);
                    div_start = (sel < 3'd4);
                    if (sel != 3'd7)
                    begin
                        wr0      = 1'b1;
                        wd0      = scale_letter(sel);
                        len_next = TXT_W'(1);
                    end
                end
            end
            ST_DIVW:
                if (div_done)
                    n_next = div_q;
            ST_KRES:
                n_next = prod_reg[41:10];
            ST_ROUND:
            begin
                n_next   = n_reg + 32'd5;
                rnd_next = 1'b1;
            end
            ST_DIG:
            begin
                n_next = q;
                if (rnd_reg)
                    rnd_next = 1'b0;
                else
                begin
                    case (job_reg.path)
                        PATH_COMPACT:
                        begin
                            wr0 = put;
                            wd0 = digit_char(r);
                            if (dot)
                            begin
                                wr1 = 1'b1;
                                wd1 = CH_DOT;
                            end
                            len_next  = len1 + TXT_W'(dot);
                            frac_next = (frac_reg == 2'd0) ? 2'd0 : frac_reg - 2'd1;
                        end
                        PATH_GROUP:
                        begin
                            wr0 = 1'b1;
                            wd0 = digit_char(r);
                            wr1 = (q != 32'd0) && (grp_reg == 2'd2);
                            wd1 = job_reg.sep;
                            len_next = len_reg + TXT_W'(1) + TXT_W'(wr1);
                            grp_next = (grp_reg == 2'd2) ? 2'd0 : grp_reg + 2'd1;
                        end
                        default:
                        begin
                            wr0      = 1'b1;
                            wd0      = digit_char(r);
                            len_next = len_reg + TXT_W'(1);
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                wr0      = 1'b1;
                len_next = len_reg + TXT_W'(1);
                if (job_reg.path == PATH_OCT)
                begin
                    wd0    = digit_char({1'b0, n_reg[2:0]});
                    n_next = n_reg >> 3;
                end
                else
                begin
                    wd0    = digit_char(n_reg[3:0]);
                    n_next = n_reg >> 4;
                end
            end
            ST_SIGN:
            begin
                pos_next = '0;
                if (job_reg.neg)
                begin
                    wr0      = 1'b1;
                    wd0      = CH_MINUS;
                    len_next = len_reg + TXT_W'(1);
                end
            end
            ST_EMIT:
                if (load)
                    pos_next = pos_reg + PW'(1);
            default:
            begin
                n_next = n_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        len_reg  <= len_next;
        frac_reg <= frac_next;
        grp_reg  <= grp_next;
        rnd_reg  <= rnd_next;
        pos_reg  <= pos_next;
        if (job_pop)
            job_reg <= job;
        if (state_reg == ST_CLASS)
            kmul_reg <= scale_mul(sel);
        if (wr0)
            text_reg[len_reg] <= wd0;
        if (wr1)
            text_reg[TXT_W'(len_reg + TXT_W'(wr0))] <= wd1;
        if (load)
        begin
            och_reg   <= in_text ? text_reg[tpos[TXT_W-1:0]] : job_reg.pad_char;
            olast_reg <= last;
        end
    end

endmodule
